/* hdl/gacsp_pkg.sv */
`timescale 1ns / 1ps
package gacsp_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_PLACE,
        ST_HITRD,
        ST_OUT
    } gacsp_state_t;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    localparam logic [1:0] REG_ATLAS_SIDE   = 2'd0;
    localparam logic [1:0] REG_ENTRY_LIMIT  = 2'd1;
    localparam logic [1:0] REG_FONTS_LOADED = 2'd2;
    localparam logic [1:0] REG_DEFAULT_FONT = 2'd3;

    localparam int unsigned HALF_PIXEL_FX = 128;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input item
        logic scan_start; // reset scan index
        logic scan_next;  // advance scan index
        logic do_flush;
        logic do_reject;
        logic do_place;   // update packer, write table
        logic do_hit;     // take result from read data
    } gacsp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_flush;
        logic font_bad;
        logic scan_done;
        logic match;
    } gacsp_stat_t;

endpackage

/* hdl/glyph_atlas_cache_shelf_packer_unit.sv */
`timescale 1ns / 1ps
// Flow: a flush or bad font goes from the read state straight to the result; a lookup
// scans entries serially until a hit or, on a miss, the entry count (up to TABLE_DEPTH).
// Throughput: one item at a time, next accepted the cycle after the result transfer;
// the serial scan over the table RAM read port sets it.
// Reset (rst_n, async low): table empty, packer at origin, registers at defaults.
// Table RAM contents are not cleared; only entries below the count are read.
module glyph_atlas_cache_shelf_packer_unit
    import gacsp_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int FONT_SLOTS  = 16,
    parameter int COORD_BITS  = 12
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [12:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // opcode, font_select, codepoint, size_fx, glyph_width, glyph_height,
    // bearing_x, bearing_y, advance_in
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // ok, hit, flushed, place_x, place_y, stored width, stored height,
    // out_bearing_x, out_bearing_y, out_advance
    output logic [95:0]  m_axis_tdata
);
    gacsp_cmd_t  cmd;
    gacsp_stat_t stat;
    logic        busy;

    assign s_axis_tready = !busy;

    gacsp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_fire(s_axis_tvalid && s_axis_tready),
        .out_fire(m_axis_tvalid && m_axis_tready),
        .stat(stat), .cmd(cmd), .busy(busy), .out_valid(m_axis_tvalid));

    gacsp_dp #(.TABLE_DEPTH(TABLE_DEPTH), .FONT_SLOTS(FONT_SLOTS),
               .COORD_BITS(COORD_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_data(s_axis_tdata), .res_data(m_axis_tdata));
endmodule

/* hdl/gacsp_ram.sv */
`timescale 1ns / 1ps
module gacsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hdl/gacsp_ctrl.sv */
`timescale 1ns / 1ps
module gacsp_ctrl
    import gacsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_fire,
    input  logic        out_fire,
    input  gacsp_stat_t stat,
    output gacsp_cmd_t  cmd,
    output logic        busy,
    output logic        out_valid
);
    gacsp_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.scan_start = 1'b1;
                if (stat.is_flush)
                begin
                    cmd.do_flush = 1'b1;
                    state_next = ST_OUT;
                end
                else if (stat.font_bad)
                begin
                    cmd.do_reject = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                // rdata holds the entry at the current scan index
                if (stat.scan_done)
                begin
                    state_next = ST_PLACE;
                end
                else if (stat.match)
                begin
                    state_next = ST_HITRD;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            ST_HITRD:
            begin
                cmd.do_hit = 1'b1;
                state_next = ST_OUT;
            end
            ST_PLACE:
            begin
                cmd.do_place = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PLACE || state_reg == ST_HITRD) |=> state_reg == ST_OUT)
        else $error("result stage not entered");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cmd.load)
        else $error("item loaded while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_fire) |=> out_valid)
        else $error("result dropped");
`endif
endmodule

/* hdl/gacsp_dp.sv */
`timescale 1ns / 1ps
module gacsp_dp
    import gacsp_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int FONT_SLOTS  = 16,
    parameter int COORD_BITS  = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  gacsp_cmd_t         cmd,
    output gacsp_stat_t        stat,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [12:0]        cfg_data,
    input  logic [111:0]       in_data,
    output logic [95:0]        res_data
);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = IW + 1;
    localparam int KW = 5 + 21 + 16;
    localparam int PW = 48;
    localparam int MW = 40;

    logic [12:0] atlas_side_reg;
    logic [10:0] entry_limit_reg;
    logic [4:0]  fonts_loaded_reg;
    logic [4:0]  default_font_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atlas_side_reg   <= 13'd1024;
            entry_limit_reg  <= 11'd1024;
            fonts_loaded_reg <= 5'd0;
            default_font_reg <= 5'h1F;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ATLAS_SIDE:   atlas_side_reg   <= cfg_data;
                REG_ENTRY_LIMIT:  entry_limit_reg  <= cfg_data[10:0];
                REG_FONTS_LOADED: fonts_loaded_reg <= cfg_data[4:0];
                REG_DEFAULT_FONT: default_font_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // captured item
    logic [106:0] item_reg;
    logic         op;
    logic [4:0]   fsel_raw, fsel;
    logic [20:0]  code;
    logic [15:0]  size;
    logic [11:0]  w, h, bx, by;
    logic [15:0]  adv;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data[106:0];
        end
    end

    assign op       = item_reg[0];
    assign fsel_raw = item_reg[5:1];
    assign code     = item_reg[26:6];
    assign size     = item_reg[42:27];
    assign w        = item_reg[54:43];
    assign h        = item_reg[66:55];
    assign bx       = item_reg[78:67];
    assign by       = item_reg[90:79];
    assign adv      = item_reg[106:91];
    assign fsel     = fsel_raw[4] ? default_font_reg : fsel_raw;

    logic [5:0] nfonts;
    assign nfonts = (fonts_loaded_reg > 5'(FONT_SLOTS) && FONT_SLOTS < 32)
                  ? 6'(FONT_SLOTS) : {1'b0, fonts_loaded_reg};

    assign stat.is_flush = (op == OP_FLUSH);
    assign stat.font_bad = fsel[4] || ({1'b0, fsel} >= nfonts);

    // packer state
    logic [CW-1:0] count_reg;
    logic [13:0]   pack_x_reg, pack_y_reg;
    logic [11:0]   row_h_reg;
    logic [CW-1:0] scan_reg;

    logic [IW-1:0] raddr;
    logic [KW-1:0] key_rd;
    logic [PW-1:0] place_rd;
    logic [MW-1:0] met_rd;

    // address issued this cycle; compare sees the previous one
    assign raddr = cmd.scan_start ? '0 :
                   (cmd.scan_next ? IW'(scan_reg + 1'b1) : IW'(scan_reg));

    logic [15:0] dsz;
    assign dsz = (key_rd[41:26] > size) ? key_rd[41:26] - size : size - key_rd[41:26];
    assign stat.scan_done = (scan_reg >= count_reg);
    assign stat.match = (key_rd[4:0] == fsel) && (key_rd[25:5] == code)
                      && (dsz < 16'(HALF_PIXEL_FX));

    logic [13:0] side;
    logic [CW-1:0] limit;
    assign side  = ({1'b0, atlas_side_reg} > 14'(1 << COORD_BITS))
                 ? 14'(1 << COORD_BITS) : {1'b0, atlas_side_reg};
    assign limit = ({{(CW > 11 ? CW - 11 : 0){1'b0}}, entry_limit_reg} > CW'(TABLE_DEPTH))
                 ? CW'(TABLE_DEPTH) : CW'(entry_limit_reg);

    // placement
    logic          wrap, full_atlas, full_tab, too_wide;
    logic [13:0]   px1, py1, px_f, py_f;
    logic [11:0]   rh1, rh_f;
    logic [CW-1:0] cnt_f;
    logic          flush_f;
    logic [15:0]   y_sum;

    always_comb
    begin
        too_wide = {2'b0, w} > side;
        wrap = ({2'b0, w} + pack_x_reg + 14'd1) > side;
        px1 = wrap ? 14'd0 : pack_x_reg;
        py1 = wrap ? 14'(pack_y_reg + {2'b0, row_h_reg} + 14'd1) : pack_y_reg;
        rh1 = wrap ? 12'd0 : row_h_reg;
        y_sum = {2'b0, py1} + {4'b0, h};
        full_atlas = (y_sum > {2'b0, side}) || (py1 >= side);
        full_tab = (count_reg >= limit) || (limit == '0);
        flush_f = full_atlas || full_tab;
        px_f = flush_f ? 14'd0 : px1;
        py_f = flush_f ? 14'd0 : py1;
        rh_f = flush_f ? 12'd0 : rh1;
        cnt_f = flush_f ? '0 : count_reg;
    end

    logic we;
    assign we = cmd.do_place && !too_wide;

    gacsp_ram #(.WIDTH(KW), .DEPTH(TABLE_DEPTH)) u_key (
        .clk(clk), .we(we), .waddr(IW'(cnt_f)), .wdata({size, code, fsel}),
        .raddr(raddr), .rdata(key_rd));
    gacsp_ram #(.WIDTH(PW), .DEPTH(TABLE_DEPTH)) u_place (
        .clk(clk), .we(we), .waddr(IW'(cnt_f)),
        .wdata({h, w, py_f[11:0], px_f[11:0]}),
        .raddr(raddr), .rdata(place_rd));
    gacsp_ram #(.WIDTH(MW), .DEPTH(TABLE_DEPTH)) u_met (
        .clk(clk), .we(we), .waddr(IW'(cnt_f)), .wdata({adv, by, bx}),
        .raddr(raddr), .rdata(met_rd));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            pack_x_reg <= '0;
            pack_y_reg <= '0;
            row_h_reg  <= '0;
            scan_reg   <= '0;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                scan_reg <= '0;
            end
            else if (cmd.scan_next)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (cmd.do_flush)
            begin
                count_reg  <= '0;
                pack_x_reg <= '0;
                pack_y_reg <= '0;
                row_h_reg  <= '0;
            end
            else if (we)
            begin
                count_reg  <= cnt_f + 1'b1;
                pack_x_reg <= 14'(px_f + {2'b0, w} + 14'd1);
                row_h_reg  <= (h > rh_f) ? h : rh_f;
                pack_y_reg <= py_f;
            end
        end
    end

    // result: {adv, by, bx, h, w, y, x, flushed, hit, ok}
    always_ff @(posedge clk)
    begin
        if (cmd.do_flush)
        begin
            res_data <= 96'b101;
        end
        else if (cmd.do_reject || (cmd.do_place && too_wide))
        begin
            res_data <= '0;
        end
        else if (cmd.do_place)
        begin
            res_data <= {5'b0, adv, by, bx, h, w, py_f[11:0], px_f[11:0],
                         flush_f, 1'b0, 1'b1};
        end
        else if (cmd.do_hit)
        begin
            res_data <= {5'b0, met_rd, place_rd, 3'b011};
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count past table depth");
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_flush |=> (count_reg == '0 && pack_x_reg == '0))
        else $error("flush left state");
`endif
endmodule

/* test/tb_glyph_atlas_cache_shelf_packer_unit.sv */
`timescale 1ns / 1ps
module tb_glyph_atlas_cache_shelf_packer_unit;
    import gacsp_pkg::*;

    localparam int DEPTH      = 1024;
    localparam int SLOTS      = 16;
    localparam int SIDE_CAP   = 4096;
    localparam int STALL_MAX  = 18;
    localparam int IDLE_LIMIT = 20000;

    // packed with the first field in the lowest bits
    typedef struct packed {
        logic [15:0] advance_in;
        logic [11:0] bearing_y;
        logic [11:0] bearing_x;
        logic [11:0] glyph_height;
        logic [11:0] glyph_width;
        logic [15:0] size_fx;
        logic [20:0] codepoint;
        logic [4:0]  font_select;
        logic        opcode;
    } glyph_req_t;

    typedef struct packed {
        logic [15:0] adv;
        logic [11:0] by;
        logic [11:0] bx;
        logic [11:0] h;
        logic [11:0] w;
        logic [11:0] py;
        logic [11:0] px;
        logic        flushed;
        logic        hit;
        logic        ok;
    } glyph_res_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [12:0]  cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [95:0]  m_axis_tdata;

    glyph_atlas_cache_shelf_packer_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #1 clk = ~clk;

    // shadow copy of the cache
    logic [4:0]  key_font [DEPTH];
    logic [20:0] key_code [DEPTH];
    logic [15:0] key_size [DEPTH];
    glyph_res_t  stored   [DEPTH];
    int          n_entries, shelf_x, shelf_y, shelf_h;
    int          side_reg = 1024, limit_reg = 1024, fonts_reg = 0;
    logic [4:0]  dflt_reg = 5'h1f;

    glyph_res_t  placement_q[$];
    int          n_sent, n_recv, n_hits, n_placed, n_flushed, n_rejects, n_bad;
    bit          no_idle;
    int          idle_cycles;

    function automatic void clear_atlas();
        n_entries = 0;
        shelf_x = 0;
        shelf_y = 0;
        shelf_h = 0;
    endfunction

    function automatic glyph_res_t atlas_predict(glyph_req_t r);
        glyph_res_t res;
        logic [4:0] f;
        int nf, side, lim, d;
        res = '0;
        if (r.opcode == OP_FLUSH)
        begin
            clear_atlas();
            res.ok = 1'b1;
            res.flushed = 1'b1;
            return res;
        end
        f = r.font_select[4] ? dflt_reg : r.font_select;
        nf = fonts_reg < SLOTS ? fonts_reg : SLOTS;
        if (f[4] || int'(f) >= nf)
            return res;
        for (int i = 0; i < n_entries; i++)
        begin
            if (key_font[i] == f && key_code[i] == r.codepoint)
            begin
                d = int'(key_size[i]) - int'(r.size_fx);
                if (d < 0)
                    d = -d;
                if (d < HALF_PIXEL_FX)
                    return stored[i];
            end
        end
        side = side_reg > SIDE_CAP ? SIDE_CAP : side_reg;
        lim = limit_reg < DEPTH ? limit_reg : DEPTH;
        if (int'(r.glyph_width) > side)
            return res;
        if (shelf_x + r.glyph_width + 1 > side)
        begin
            shelf_x = 0;
            shelf_y = shelf_y + shelf_h + 1;
            shelf_h = 0;
        end
        if (shelf_y + r.glyph_height > side || shelf_y >= side)
        begin
            clear_atlas();
            res.flushed = 1'b1;
        end
        if (n_entries >= lim)
        begin
            clear_atlas();
            res.flushed = 1'b1;
        end
        res.ok = 1'b1;
        res.px = shelf_x[11:0];
        res.py = shelf_y[11:0];
        res.w = r.glyph_width;
        res.h = r.glyph_height;
        res.bx = r.bearing_x;
        res.by = r.bearing_y;
        res.adv = r.advance_in;
        key_font[n_entries] = f;
        key_code[n_entries] = r.codepoint;
        key_size[n_entries] = r.size_fx;
        stored[n_entries] = res;
        stored[n_entries].flushed = 1'b0;
        stored[n_entries].hit = 1'b1;
        n_entries++;
        shelf_x = shelf_x + r.glyph_width + 1;
        if (r.glyph_height > shelf_h)
            shelf_h = r.glyph_height;
        return res;
    endfunction

    task automatic send_glyph(glyph_req_t r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, STALL_MAX);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'b0, r};
        do
            @(posedge clk);
        while (!s_axis_tready);
        placement_q.push_back(atlas_predict(r));
        n_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (placement_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[12:0];
        case (idx)
            REG_ATLAS_SIDE:   side_reg = val & 13'h1fff;
            REG_ENTRY_LIMIT:  limit_reg = val & 11'h7ff;
            REG_FONTS_LOADED: fonts_reg = val & 5'h1f;
            REG_DEFAULT_FONT: dflt_reg = val[4:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic glyph_req_t glyph(int f, int code, int size, int w, int h);
        glyph_req_t r;
        r.opcode = OP_LOOKUP;
        r.font_select = f[4:0];
        r.codepoint = code[20:0];
        r.size_fx = size[15:0];
        r.glyph_width = w[11:0];
        r.glyph_height = h[11:0];
        r.bearing_x = 12'($urandom);
        r.bearing_y = 12'($urandom);
        r.advance_in = 16'($urandom);
        return r;
    endfunction

    function automatic glyph_req_t flush_req();
        glyph_req_t r;
        r = glyph(0, 0, 0, 0, 0);
        r.opcode = OP_FLUSH;
        return r;
    endfunction

    task automatic note_field(string nm, logic [15:0] e, logic [15:0] a);
        if (e !== a)
        begin
            n_bad++;
            if (n_bad <= 10)
                $display("mismatch on result %0d, %s: expected %0h got %0h",
                         n_recv, nm, e, a);
        end
    endtask

    // result side: random stalls per transfer, none while no_idle is set
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, STALL_MAX);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin
        glyph_res_t e, a;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            a = m_axis_tdata[90:0];
            if (placement_q.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected result transfer %0h", a);
            end
            else
            begin
                e = placement_q.pop_front();
                note_field("ok", e.ok, a.ok);
                note_field("hit", e.hit, a.hit);
                note_field("flushed", e.flushed, a.flushed);
                note_field("place_x", e.px, a.px);
                note_field("place_y", e.py, a.py);
                note_field("stored_width", e.w, a.w);
                note_field("stored_height", e.h, a.h);
                note_field("out_bearing_x", e.bx, a.bx);
                note_field("out_bearing_y", e.by, a.by);
                note_field("out_advance", e.adv, a.adv);
                if (e.hit)
                    n_hits++;
                else if (e.flushed)
                    n_flushed++;
                else if (e.ok)
                    n_placed++;
                else
                    n_rejects++;
            end
            n_recv++;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("glyph_atlas_cache_shelf_packer_unit regression: fail");
            $finish;
        end
    end

    task automatic test_reset_defaults();
        send_glyph(glyph(0, 65, 1024, 8, 8));    // no fonts loaded yet
        send_glyph(glyph(-1, 65, 1024, 8, 8));
        send_glyph(flush_req());
        wait_drained();
    endtask

    task automatic test_directed();
        write_reg(REG_FONTS_LOADED, 16);
        write_reg(REG_DEFAULT_FONT, -1);
        send_glyph(glyph(-1, 66, 1024, 8, 8));   // default means none
        send_glyph(glyph(15, 1114111, 65535, 4095, 4095)); // too wide
        send_glyph(glyph(15, 1114111, 65535, 20, 4095));   // taller than atlas
        send_glyph(glyph(15, 1114111, 65535 - 127, 1, 1)); // within half pixel
        send_glyph(glyph(0, 0, 0, 1024, 0));     // full width
        send_glyph(glyph(0, 0, 128, 0, 0));      // half pixel apart: miss
        send_glyph(glyph(0, 0, 127, 5, 5));      // hit
        wait_drained();
        write_reg(REG_DEFAULT_FONT, 3);
        send_glyph(glyph(-16, 0, 0, 3, 3));      // resolves to font 3
        send_glyph(glyph(3, 0, 0, 3, 3));        // hit via explicit font
        wait_drained();
        write_reg(REG_ATLAS_SIDE, 16);
        write_reg(REG_ENTRY_LIMIT, 3);
        for (int i = 0; i < 6; i++)
            send_glyph(glyph(1, 100 + i, 512, 7, 6)); // shelves fill, atlas wraps
        send_glyph(glyph(1, 101, 512, 2, 2));
        wait_drained();
        write_reg(REG_ENTRY_LIMIT, 0);
        send_glyph(glyph(2, 7, 300, 1, 1));
        send_glyph(glyph(2, 8, 300, 1, 1));
        send_glyph(glyph(2, 8, 300, 1, 1));
        wait_drained();
    endtask

    function automatic glyph_req_t random_glyph();
        glyph_req_t r;
        int side, lim_w;
        side = side_reg > SIDE_CAP ? SIDE_CAP : side_reg;
        lim_w = side / 6 > 4095 ? 4095 : side / 6;
        r = glyph($urandom_range(0, 3), $urandom_range(0, 11),
                  $urandom_range(0, 767), $urandom_range(0, lim_w),
                  $urandom_range(0, lim_w));
        if ($urandom_range(0, 9) == 0)
            r.font_select = 5'($urandom);
        if ($urandom_range(0, 9) == 0)
            r.codepoint = 21'($urandom_range(0, 1114111));
        if ($urandom_range(0, 9) == 0)
            r.size_fx = 16'($urandom);
        if ($urandom_range(0, 14) == 0)
            r.glyph_width = 12'($urandom);
        if ($urandom_range(0, 14) == 0)
            r.glyph_height = 12'($urandom);
        if ($urandom_range(0, 39) == 0)
            r.opcode = OP_FLUSH;
        return r;
    endfunction

    task automatic test_random();
        int sides[6] = '{16, 4096, 8191, 64, 1024, 300};
        int lims[6]  = '{1, 1024, 2047, 5, 0, 40};
        for (int ph = 0; ph < 11; ph++)
        begin
            write_reg(REG_ATLAS_SIDE, ph < 6 ? sides[ph] : $urandom_range(16, 4096));
            write_reg(REG_ENTRY_LIMIT, ph < 6 ? lims[ph] : $urandom_range(1, 1024));
            write_reg(REG_FONTS_LOADED, ph == 3 ? 31 : $urandom_range(1, 16));
            write_reg(REG_DEFAULT_FONT, $urandom_range(0, 31));
            no_idle = (ph % 4 == 2);
            for (int i = 0; i < 53; i++)
            begin
                send_glyph(random_glyph());
                if (i == 26)
                    wait_drained();  // sender holds off until all results are back
            end
            wait_drained();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        clear_atlas();
        test_reset_defaults();
        test_directed();
        test_random();
        wait_drained();
        repeat (20) @(posedge clk);
        $display("%0d lookups sent, %0d results: %0d hits, %0d placed, %0d with flush,",
                 n_sent, n_recv, n_hits, n_placed, n_flushed);
        $display("%0d rejected; atlas sides 16..8191, entry limits 0..2047", n_rejects);
        if (n_bad == 0 && placement_q.size() == 0)
            $display("glyph_atlas_cache_shelf_packer_unit regression: pass");
        else
            $display("glyph_atlas_cache_shelf_packer_unit regression: fail");
        $finish;
    end

endmodule
